// File: sv/grp_pkg.sv
// ----------------------------------------------------------------------------
// grp_pkg: shared types and constants of the grid rectangle packer
// Sizes of the rectangle store and the occupancy grid, and the control states.
// ----------------------------------------------------------------------------
package grp_pkg;

    localparam int MAX_RECTS = 32;
    localparam int GRID_SIDE = 64;

    localparam int IDX_W   = $clog2(MAX_RECTS);
    localparam int CNT_W   = $clog2(MAX_RECTS + 1);
    localparam int DIM_W   = 7;
    localparam int POS_W   = $clog2(GRID_SIDE);
    localparam int CELL_AW = 2 * POS_W;
    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int OWN_W   = $clog2(MAX_RECTS + 1);
    localparam int AREA_W  = 2 * DIM_W;

    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_AW-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Blocker scan order: two bottom corners first, then the whole box.
    typedef enum logic [1:0] {
        PH_LEFT_CORNER,
        PH_RIGHT_CORNER,
        PH_RASTER
    } scan_phase_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_CLEAR,
        ST_SORT_LD,
        ST_SORT_CMP,
        ST_SORT_WR,
        ST_FIRST,
        ST_PLACE_INIT,
        ST_ROW,
        ST_SCAN,
        ST_JUMP,
        ST_EVAL,
        ST_NEXT_ROW,
        ST_COMMIT,
        ST_MARK,
        ST_OUT
    } state_t;

endpackage

// File: sv/grid_rectangle_packer_core.sv
// ----------------------------------------------------------------------------
// grid_rectangle_packer_core: greedy rectangle packer on an occupancy grid
// Loads rectangle sizes, sorts them, places each one at the free spot with the
// smallest bounding area and reports every position in input order.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata: rect_width, rect_height; tlast: last
// m_axis    out        tdata: rect_index, pos_x, pos_y, total_width,
//                      total_height; tuser: success; tlast: last_result
// cfg       in         index 0 grid_width, index 1 grid_height
//
// Loading takes one item per cycle. An item with last starts the pack, during
// which s_tready is low: a size check of each item, a clearing pass over all
// 4096 cells of the grid RAM, a sort, then a placement whose length depends on
// the grid scan (one grid RAM read per cycle) and marking (one cell written per
// cycle). Results then leave one per cycle unless m_tready stalls them. Reset
// returns to loading with an empty store.
// ----------------------------------------------------------------------------
module grid_rectangle_packer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // rect_width [6:0], rect_height [13:7], zero [15:14]
    input  logic [grp_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // rect_index [4:0], pos_x [10:5], pos_y [16:11], total_width [23:17],
    // total_height [30:24], zero [31]
    output logic [grp_pkg::OUT_DATA_W-1:0] m_tdata,
    // success [0]
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [grp_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [grp_pkg::DIM_W-1:0]     cfg_wdata
);

    import grp_pkg::*;

    localparam logic [DIM_W-1:0] SIDE = DIM_W'(GRID_SIDE);

    state_t state_reg, state_next;

    logic [DIM_W-1:0] gw_reg, gh_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [DIM_W-1:0] size_w_reg [MAX_RECTS];
    logic [DIM_W-1:0] size_h_reg [MAX_RECTS];
    logic [POS_W-1:0] plx_reg [MAX_RECTS];
    logic [POS_W-1:0] ply_reg [MAX_RECTS];
    logic [IDX_W-1:0] ord_reg [MAX_RECTS];

    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [IDX_W-1:0] rank_reg, rank_next, cur_reg, cur_next;
    logic [DIM_W-1:0] wi_reg, wi_next, hi_reg, hi_next;
    logic [DIM_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [DIM_W-1:0] lx_reg, lx_next, ly_reg, ly_next;
    logic [DIM_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [DIM_W-1:0] bw_reg, bw_next, bh_reg, bh_next;
    logic [DIM_W-1:0] bsx_reg, bsx_next, bsy_reg, bsy_next;
    logic [POS_W-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [AREA_W-1:0] barea_reg, barea_next;
    logic             found_reg, found_next, interior_reg, interior_next;
    logic             ok_reg, ok_next;
    scan_phase_t      ph_reg, ph_next;
    logic [POS_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [POS_W-1:0] mx_reg, mx_next, my_reg, my_next;
    logic [CELL_AW-1:0] clr_reg, clr_next;
    logic [OWN_W-1:0] blk_reg, blk_next;

    logic                  mv_reg, mv_next, ml_reg, ml_next, mu_reg, mu_next;
    logic [OUT_DATA_W-1:0] md_reg, md_next;

    // Shared read port of the small stores.
    logic [IDX_W-1:0] rd_idx;
    logic [DIM_W-1:0] rd_w, rd_h;
    logic [POS_W-1:0] rd_px, rd_py;
    logic [IDX_W-1:0] ord_i;

    logic [DIM_W-1:0] gw_e, gh_e;
    logic             in_acc, last_i, bad_size, before_ji, slot_free;
    logic [POS_W-1:0] xe, ye, x6, y6;
    logic             scan_last;
    logic [DIM_W-1:0] nsx, nsy;
    logic [AREA_W-1:0] area;
    logic [POS_W-1:0] mxe, mye;
    logic             mark_end;

    logic               ram_we;
    logic [CELL_AW-1:0] ram_waddr;
    logic [OWN_W-1:0]   ram_wdata, ram_rdata;

    logic st_wr, sort_wr, place_wr;
    logic [POS_W-1:0] place_x_wr, place_y_wr;

    grp_ram #(
        .WIDTH (OWN_W),
        .DEPTH (CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr ({cy_next, cx_next}),
        .rdata (ram_rdata)
    );

    // Effective grid size and common conditions.
    assign gw_e      = (gw_reg > SIDE) ? SIDE : gw_reg;
    assign gh_e      = (gh_reg > SIDE) ? SIDE : gh_reg;
    assign s_tready  = (state_reg == ST_LOAD);
    assign in_acc    = s_tvalid && s_tready;
    assign last_i    = (i_reg + CNT_W'(1) == cnt_reg);
    assign slot_free = !mv_reg || m_tready;

    assign ord_i = ord_reg[i_reg[IDX_W-1:0]];

    // Index for the shared read of sizes and positions.
    always_comb
    begin
        unique case (state_reg)
            ST_CHECK, ST_SORT_LD, ST_OUT: rd_idx = i_reg[IDX_W-1:0];
            ST_SORT_CMP:                  rd_idx = j_reg[IDX_W-1:0];
            ST_FIRST, ST_PLACE_INIT:      rd_idx = ord_i;
            ST_JUMP:                      rd_idx = IDX_W'(blk_reg - OWN_W'(1));
            default:                      rd_idx = cur_reg;
        endcase
    end

    assign rd_w  = size_w_reg[rd_idx];
    assign rd_h  = size_h_reg[rd_idx];
    assign rd_px = plx_reg[rd_idx];
    assign rd_py = ply_reg[rd_idx];

    assign bad_size  = (rd_w == '0) || (rd_h == '0) || (rd_w > gw_e) || (rd_h > gh_e);
    assign before_ji = (rd_h > hi_reg) ||
                       ((rd_h == hi_reg) && ((rd_w > wi_reg) ||
                        ((rd_w == wi_reg) && (j_reg < i_reg))));

    // Candidate box corners and blocker scan end.
    assign x6        = x_reg[POS_W-1:0];
    assign y6        = y_reg[POS_W-1:0];
    assign xe        = POS_W'(x_reg + sx_reg - DIM_W'(1));
    assign ye        = POS_W'(y_reg + sy_reg - DIM_W'(1));
    assign scan_last = (ph_reg == PH_RASTER) && (cx_reg == xe) && (cy_reg == ye);

    // Bounding box and area of a free spot.
    always_comb
    begin
        nsx  = (x_reg + sx_reg > bw_reg) ? (x_reg + sx_reg) : bw_reg;
        nsy  = (y_reg + sy_reg > bh_reg) ? (y_reg + sy_reg) : bh_reg;
        area = AREA_W'(nsx) * AREA_W'(nsy);
    end

    assign mxe      = POS_W'(DIM_W'(rd_px) + rd_w - DIM_W'(1));
    assign mye      = POS_W'(DIM_W'(rd_py) + rd_h - DIM_W'(1));
    assign mark_end = (mx_reg == mxe) && (my_reg == mye);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && s_tlast)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (bad_size)
                begin
                    state_next = ST_OUT;
                end
                else if (last_i)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_SORT_LD;
                end
            end
            ST_SORT_LD:  state_next = ST_SORT_CMP;
            ST_SORT_CMP:
            begin
                if (j_reg + CNT_W'(1) == cnt_reg)
                begin
                    state_next = ST_SORT_WR;
                end
            end
            ST_SORT_WR:  state_next = last_i ? ST_FIRST : ST_SORT_LD;
            ST_FIRST:    state_next = ST_MARK;
            ST_PLACE_INIT: state_next = ST_ROW;
            ST_ROW:      state_next = (x_reg > lx_reg) ? ST_NEXT_ROW : ST_SCAN;
            ST_SCAN:
            begin
                if (ram_rdata != '0)
                begin
                    state_next = ST_JUMP;
                end
                else if (scan_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_JUMP:     state_next = ST_ROW;
            ST_EVAL:     state_next = ST_NEXT_ROW;
            ST_NEXT_ROW:
            begin
                if (interior_reg || (y_reg + DIM_W'(1) > ly_reg))
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_ROW;
                end
            end
            ST_COMMIT:   state_next = found_reg ? ST_MARK : ST_OUT;
            ST_MARK:
            begin
                if (mark_end)
                begin
                    state_next = last_i ? ST_OUT : ST_PLACE_INIT;
                end
            end
            ST_OUT:
            begin
                if (slot_free && last_i)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    // Datapath and output register updates.
    always_comb
    begin
        cnt_next      = cnt_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rank_next     = rank_reg;
        cur_next      = cur_reg;
        wi_next       = wi_reg;
        hi_next       = hi_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        lx_next       = lx_reg;
        ly_next       = ly_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        bw_next       = bw_reg;
        bh_next       = bh_reg;
        bsx_next      = bsx_reg;
        bsy_next      = bsy_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        barea_next    = barea_reg;
        found_next    = found_reg;
        interior_next = interior_reg;
        ok_next       = ok_reg;
        ph_next       = ph_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        clr_next      = clr_reg;
        blk_next      = blk_reg;
        mv_next       = mv_reg && !m_tready;
        md_next       = md_reg;
        mu_next       = mu_reg;
        ml_next       = ml_reg;
        ram_we        = 1'b0;
        ram_waddr     = {my_reg, mx_reg};
        ram_wdata     = OWN_W'(cur_reg) + OWN_W'(1);
        st_wr         = 1'b0;
        sort_wr       = 1'b0;
        place_wr      = 1'b0;
        place_x_wr    = bx_reg;
        place_y_wr    = by_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (cnt_reg < CNT_W'(MAX_RECTS))
                    begin
                        st_wr    = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    i_next = '0;
                end
            end
            ST_CHECK:
            begin
                i_next   = i_reg + CNT_W'(1);
                clr_next = '0;
                if (bad_size)
                begin
                    ok_next = 1'b0;
                    i_next  = '0;
                end
                else if (last_i)
                begin
                    i_next = '0;
                end
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + CELL_AW'(1);
            end
            ST_SORT_LD:
            begin
                wi_next   = rd_w;
                hi_next   = rd_h;
                j_next    = '0;
                rank_next = '0;
            end
            ST_SORT_CMP:
            begin
                if (before_ji)
                begin
                    rank_next = rank_reg + IDX_W'(1);
                end
                j_next = j_reg + CNT_W'(1);
            end
            ST_SORT_WR:
            begin
                sort_wr = 1'b1;
                i_next  = last_i ? '0 : (i_reg + CNT_W'(1));
            end
            ST_FIRST:
            begin
                cur_next   = ord_i;
                place_wr   = 1'b1;
                place_x_wr = '0;
                place_y_wr = '0;
                bw_next    = rd_w;
                bh_next    = rd_h;
                mx_next    = '0;
                my_next    = '0;
            end
            ST_PLACE_INIT:
            begin
                cur_next      = ord_i;
                sx_next       = rd_w;
                sy_next       = rd_h;
                lx_next       = (bw_reg < gw_e - rd_w) ? bw_reg : (gw_e - rd_w);
                ly_next       = (bh_reg < gh_e - rd_h) ? bh_reg : (gh_e - rd_h);
                x_next        = '0;
                y_next        = '0;
                found_next    = 1'b0;
                interior_next = 1'b0;
            end
            ST_ROW:
            begin
                if (x_reg <= lx_reg)
                begin
                    ph_next = PH_LEFT_CORNER;
                    cx_next = x6;
                    cy_next = ye;
                end
            end
            ST_SCAN:
            begin
                blk_next = ram_rdata;
                if ((ram_rdata == '0) && !scan_last)
                begin
                    unique case (ph_reg)
                        PH_LEFT_CORNER:
                        begin
                            ph_next = PH_RIGHT_CORNER;
                            cx_next = xe;
                        end
                        PH_RIGHT_CORNER:
                        begin
                            ph_next = PH_RASTER;
                            cx_next = x6;
                            cy_next = y6;
                        end
                        default:
                        begin
                            if (cx_reg == xe)
                            begin
                                cx_next = x6;
                                cy_next = cy_reg + POS_W'(1);
                            end
                            else
                            begin
                                cx_next = cx_reg + POS_W'(1);
                            end
                        end
                    endcase
                end
            end
            ST_JUMP:
            begin
                x_next = DIM_W'(rd_px) + rd_w;
            end
            ST_EVAL:
            begin
                if (!found_reg || (barea_reg > area))
                begin
                    found_next    = 1'b1;
                    bx_next       = x6;
                    by_next       = y6;
                    bsx_next      = nsx;
                    bsy_next      = nsy;
                    barea_next    = area;
                    interior_next = (nsx == bw_reg) && (nsy == bh_reg);
                end
            end
            ST_NEXT_ROW:
            begin
                y_next = y_reg + DIM_W'(1);
                x_next = '0;
            end
            ST_COMMIT:
            begin
                if (found_reg)
                begin
                    place_wr = 1'b1;
                    bw_next  = bsx_reg;
                    bh_next  = bsy_reg;
                    mx_next  = bx_reg;
                    my_next  = by_reg;
                end
                else
                begin
                    ok_next = 1'b0;
                    i_next  = '0;
                end
            end
            ST_MARK:
            begin
                ram_we = 1'b1;
                if (mark_end)
                begin
                    if (last_i)
                    begin
                        ok_next = 1'b1;
                        i_next  = '0;
                    end
                    else
                    begin
                        i_next = i_reg + CNT_W'(1);
                    end
                end
                else if (mx_reg == mxe)
                begin
                    mx_next = rd_px;
                    my_next = my_reg + POS_W'(1);
                end
                else
                begin
                    mx_next = mx_reg + POS_W'(1);
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    mv_next = 1'b1;
                    mu_next = ok_reg;
                    ml_next = last_i;
                    md_next = {1'b0,
                               (ok_reg && last_i) ? bh_reg : DIM_W'(0),
                               (ok_reg && last_i) ? bw_reg : DIM_W'(0),
                               ok_reg ? rd_py : POS_W'(0),
                               ok_reg ? rd_px : POS_W'(0),
                               i_reg[IDX_W-1:0]};
                    i_next  = i_reg + CNT_W'(1);
                    if (last_i)
                    begin
                        cnt_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            gw_reg    <= SIDE;
            gh_reg    <= SIDE;
            mv_reg    <= 1'b0;
            bw_reg    <= '0;
            bh_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
            bw_reg    <= bw_next;
            bh_reg    <= bh_next;
            if (cfg_we && (cfg_addr == REG_GRID_WIDTH))
            begin
                gw_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_addr == REG_GRID_HEIGHT))
            begin
                gh_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers and small stores.
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        rank_reg     <= rank_next;
        cur_reg      <= cur_next;
        wi_reg       <= wi_next;
        hi_reg       <= hi_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        lx_reg       <= lx_next;
        ly_reg       <= ly_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        bsx_reg      <= bsx_next;
        bsy_reg      <= bsy_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        barea_reg    <= barea_next;
        found_reg    <= found_next;
        interior_reg <= interior_next;
        ok_reg       <= ok_next;
        ph_reg       <= ph_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        clr_reg      <= clr_next;
        blk_reg      <= blk_next;
        md_reg       <= md_next;
        mu_reg       <= mu_next;
        ml_reg       <= ml_next;
        if (st_wr)
        begin
            size_w_reg[cnt_reg[IDX_W-1:0]] <= s_tdata[DIM_W-1:0];
            size_h_reg[cnt_reg[IDX_W-1:0]] <= s_tdata[2*DIM_W-1:DIM_W];
        end
        if (sort_wr)
        begin
            ord_reg[rank_reg] <= i_reg[IDX_W-1:0];
        end
        if (place_wr)
        begin
            plx_reg[cur_next] <= place_x_wr;
            ply_reg[cur_next] <= place_y_wr;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

endmodule

// File: sv/grp_ram.sv
// ----------------------------------------------------------------------------
// grp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module grp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: sv/grp_checker.sv
// ----------------------------------------------------------------------------
// grp_checker: port-level checks of the grid rectangle packer
// Watches the stream ports and checks result framing over time.
// ----------------------------------------------------------------------------
module grp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [grp_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    import grp_pkg::*;

    localparam int TOT_LO = IDX_W + 2 * POS_W;

    // A stalled result item holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // A failed pack reports no positions and no bounding box.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[OUT_DATA_W-1:IDX_W] == '0)
        else $error("failed pack carries position data");

    // Only the final result of a run carries the bounding box.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[OUT_DATA_W-1:TOT_LO] == '0)
        else $error("bounding box on a non-final result");

    // The final input item of a set starts the pack and stops input.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still accepted after the final item");

endmodule

bind grid_rectangle_packer_core grp_checker u_grp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
